[design/bilinear_subpixel_shift_defines.svh]
// bilinear_subpixel_shift_defines.svh: assertion macros shared by the bsps modules
// expects clk and rst_n in the scope of each use; empty when SYNTHESIS is defined
`ifndef BILINEAR_SUBPIXEL_SHIFT_DEFINES_SVH
`define BILINEAR_SUBPIXEL_SHIFT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BSPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsps: check failed");

// next-cycle implication
`define BSPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsps: check failed");

`else

`define BSPS_ASSERT_NOW(label, ante, cons)
`define BSPS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[design/bsps_pkg.sv]
// bsps_pkg: widths, register indexes and control structs of the sub-pixel shifter
// no dependencies; used by every other file of the block but the defines header
package bsps_pkg;

    localparam int BYTE_W      = 8;
    localparam int FRAC_W      = 4;
    localparam int CHAN_W      = 3;
    localparam int WIDTH_W     = 10;
    localparam int HEIGHT_W    = 12;
    localparam int COUNT_W     = 12;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int MAX_CHANS   = 4;
    localparam int CH_W        = 2;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAC_X   = 3'd0,
        REG_FRAC_Y   = 3'd1,
        REG_CHANNELS = 3'd2,
        REG_WIDTH    = 3'd3,
        REG_HEIGHT   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [CHAN_W-1:0]   chans;
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
    } geom_t;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            produce;
        logic            row_end;
        logic            frame_end;
    } item_ctrl_t;

endpackage

[design/bsps_stream_if.sv]
// bsps_src_if and bsps_dst_if: valid/ready channels of the sub-pixel shifter
// depends on bsps_pkg
interface bsps_src_if
    import bsps_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t src_byte;

    modport source (output valid, output src_byte, input ready);
    modport sink (input valid, input src_byte, output ready);
endinterface

interface bsps_dst_if
    import bsps_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  row_end;
    logic  frame_end;

    modport source (output valid, output out_byte, output row_end, output frame_end,
                    input ready);
    modport sink (input valid, input out_byte, input row_end, input frame_end,
                  output ready);
endinterface

[design/bsps_line_mem.sv]
// bsps_line_mem: one-row line store, single port, read-before-write, registered read
// depends on bsps_pkg
module bsps_line_mem
    import bsps_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          en,
    input  logic [AW-1:0] addr,
    input  byte_t         wdata,
    output byte_t         rdata
);

    byte_t store_mem [DEPTH];
    byte_t rdata_reg;

    // old entry comes out while the new byte goes in
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg       <= store_mem[addr];
            store_mem[addr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/bsps_addr_gen.sv]
// bsps_addr_gen: column/row counters, line store address, channel slot and beat flags
// depends on bsps_pkg and bilinear_subpixel_shift_defines.svh
`include "bilinear_subpixel_shift_defines.svh"

module bsps_addr_gen
    import bsps_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  geom_t         geom,
    input  logic          acc,
    output logic [AW-1:0] addr,
    output item_ctrl_t    ctrl
);

    logic [COUNT_W-1:0]  col_reg, col_next;
    logic [COUNT_W-1:0]  row_reg, row_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [1:0]          mod3_reg, mod3_next;

    logic [CHAN_W-1:0]   chans_c;
    logic [WIDTH_W-1:0]  width_c;
    logic [HEIGHT_W-1:0] height_c;
    logic [WIDTH_W:0]    src_pixels;
    logic [COUNT_W:0]    row_bytes;
    logic [COUNT_W:0]    row_bytes_m1;
    logic                last_col;
    logic                last_row;

    always_comb
    begin
        if (geom.chans == '0)
            chans_c = CHAN_W'(1);
        else if (geom.chans > CHAN_W'(MAX_CHANS))
            chans_c = CHAN_W'(MAX_CHANS);
        else
            chans_c = geom.chans;
        width_c  = (geom.width == '0) ? WIDTH_W'(1) : geom.width;
        height_c = (geom.height == '0) ? HEIGHT_W'(1) : geom.height;
    end

    assign src_pixels   = {1'b0, width_c} + (WIDTH_W+1)'(1);
    assign row_bytes    = (COUNT_W+1)'(src_pixels) * (COUNT_W+1)'(chans_c);
    assign row_bytes_m1 = row_bytes - (COUNT_W+1)'(1);
    assign last_col     = col_reg >= row_bytes_m1[COUNT_W-1:0];
    assign last_row     = row_reg >= height_c;

    always_comb
    begin
        ctrl.produce   = (row_reg != '0) && (col_reg >= COUNT_W'(chans_c));
        ctrl.row_end   = last_col;
        ctrl.frame_end = last_col && last_row;
        case (chans_c)
            3'd1:    ctrl.ch = '0;
            3'd2:    ctrl.ch = {1'b0, col_reg[0]};
            3'd3:    ctrl.ch = mod3_reg;
            default: ctrl.ch = col_reg[CH_W-1:0];
        endcase
    end

    assign addr = pos_reg;

    // pos and mod3 track the column count modulo the store depth and modulo three
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        pos_next  = pos_reg;
        mod3_next = mod3_reg;
        if (acc)
        begin
            if (last_col)
            begin
                col_next  = '0;
                pos_next  = '0;
                mod3_next = '0;
                row_next  = last_row ? '0 : row_reg + COUNT_W'(1);
            end
            else
            begin
                col_next  = col_reg + COUNT_W'(1);
                pos_next  = (pos_reg == AW'(DEPTH - 1)) ? '0 : pos_reg + AW'(1);
                mod3_next = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pos_reg  <= '0;
            mod3_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pos_reg  <= pos_next;
            mod3_reg <= mod3_next;
        end
    end

    `BSPS_ASSERT_NEXT(a_row_wraps_column, acc && last_col, col_reg == '0)
    `BSPS_ASSERT_NOW(a_column_zero_aligned, col_reg == '0, pos_reg == '0 && mod3_reg == 2'd0)
    `BSPS_ASSERT_NEXT(a_counters_hold_idle, !acc, $stable(col_reg) && $stable(row_reg))

endmodule

[design/bsps_interp.sv]
// bsps_interp: neighbor delays, horizontal then vertical blend, output register
// depends on bsps_pkg, bsps_stream_if and bilinear_subpixel_shift_defines.svh
`include "bilinear_subpixel_shift_defines.svh"

module bsps_interp
    import bsps_pkg::*;
#(
    parameter int FRACTION_BITS = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     acc,
    input  item_ctrl_t               ctrl,
    input  byte_t                    src_byte,
    input  byte_t                    upper_byte,
    input  logic [FRACTION_BITS-1:0] fx,
    input  logic [FRACTION_BITS-1:0] fy,
    output logic                     take,
    bsps_dst_if.source               dst
);

    localparam int WT_W = FRACTION_BITS + 1;
    localparam int H_W  = BYTE_W + FRACTION_BITS;
    localparam int S_W  = BYTE_W + 2 * FRACTION_BITS;
    localparam logic [WT_W-1:0] FULL  = WT_W'(1) << FRACTION_BITS;
    localparam logic [S_W-1:0]  ROUND = S_W'(1) << (2 * FRACTION_BITS - 1);

    logic [WT_W-1:0] wx0, wx1, wy0, wy1;

    // stage 1: line store data and the carried incoming byte
    logic       s1_valid_reg, s1_valid_next;
    item_ctrl_t s1_ctrl_reg;
    byte_t      s1_d_reg;
    byte_t      upper_dly_reg [MAX_CHANS];
    byte_t      lower_dly_reg [MAX_CHANS];
    byte_t      pix_a, pix_c;

    // stage 2: horizontal blends
    logic           s2_valid_reg, s2_valid_next;
    logic [H_W-1:0] htop_reg, htop_next;
    logic [H_W-1:0] hbot_reg, hbot_next;
    logic           s2_row_end_reg;
    logic           s2_frame_end_reg;
    logic [S_W-1:0] sum_next;

    // output register
    logic  out_valid_reg, out_valid_next;
    byte_t out_byte_reg;
    logic  row_end_reg;
    logic  frame_end_reg;

    logic out_free, s2_free, s1_move, s2_move;

    assign wx0 = {1'b0, fx};
    assign wx1 = FULL - wx0;
    assign wy0 = {1'b0, fy};
    assign wy1 = FULL - wy0;

    assign out_free = !out_valid_reg || dst.ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s2_move  = s2_valid_reg && out_free;
    assign s1_move  = s1_valid_reg && s2_free;
    assign take     = !s1_valid_reg || s2_free;

    assign pix_a = upper_dly_reg[s1_ctrl_reg.ch];
    assign pix_c = lower_dly_reg[s1_ctrl_reg.ch];

    assign htop_next = H_W'(wx1) * H_W'(pix_a) + H_W'(wx0) * H_W'(upper_byte);
    assign hbot_next = H_W'(wx1) * H_W'(pix_c) + H_W'(wx0) * H_W'(s1_d_reg);
    assign sum_next  = S_W'(wy1) * S_W'(htop_reg) + S_W'(wy0) * S_W'(hbot_reg) + ROUND;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (acc)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;

        s2_valid_next = s2_valid_reg;
        if (s1_move)
            s2_valid_next = s1_ctrl_reg.produce;
        else if (s2_move)
            s2_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s2_move)
            out_valid_next = 1'b1;
        else if (dst.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CHANS; i++)
            begin
                upper_dly_reg[i] <= '0;
                lower_dly_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            // the left neighbors move on once the item leaves stage 1
            if (s1_move)
            begin
                upper_dly_reg[s1_ctrl_reg.ch] <= upper_byte;
                lower_dly_reg[s1_ctrl_reg.ch] <= s1_d_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_ctrl_reg <= ctrl;
            s1_d_reg    <= src_byte;
        end
        if (s1_move)
        begin
            htop_reg         <= htop_next;
            hbot_reg         <= hbot_next;
            s2_row_end_reg   <= s1_ctrl_reg.row_end;
            s2_frame_end_reg <= s1_ctrl_reg.frame_end;
        end
        if (s2_move)
        begin
            out_byte_reg  <= sum_next[2*FRACTION_BITS +: BYTE_W];
            row_end_reg   <= s2_row_end_reg;
            frame_end_reg <= s2_frame_end_reg;
        end
    end

    assign dst.valid     = out_valid_reg;
    assign dst.out_byte  = out_byte_reg;
    assign dst.row_end   = row_end_reg;
    assign dst.frame_end = frame_end_reg;

    `BSPS_ASSERT_NEXT(a_s2_held_on_stall, out_valid_reg && !dst.ready && s2_valid_reg, s2_valid_reg)
    `BSPS_ASSERT_NEXT(a_s1_held_on_stall, s1_valid_reg && !s2_free, s1_valid_reg)
    `BSPS_ASSERT_NOW(a_frame_end_on_row_end, out_valid_reg && frame_end_reg, row_end_reg)

endmodule

[design/bilinear_subpixel_shift.sv]
// bilinear_subpixel_shift: top level of the bilinear sub-pixel image shifter
// depends on bsps_pkg, bsps_stream_if, bsps_line_mem, bsps_addr_gen, bsps_interp
//
//   channel  dir  payload                              handshake
//   src      in   src_byte[7:0]                        valid / ready
//   dst      out  out_byte[7:0], row_end, frame_end    valid / ready
//   cfg      in   cfg_index[2:0], cfg_wdata[11:0]      cfg_we, always taken
//
// one source byte per clock while dst does not stall; the single line store port
// reads the old byte and writes the new one in the same cycle
// a result beat follows its source byte through the line store read, the
// horizontal blend and the vertical blend into the output register
// reset clears counters, neighbor delays, stage valids and config to defaults;
// the line store is not cleared
// dst backpressure stalls stage by stage; src ready drops only once all are full
module bilinear_subpixel_shift
    import bsps_pkg::*;
#(
    parameter int MAX_ROW_BYTES = 4096,
    parameter int FRACTION_BITS = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    bsps_src_if.sink               src,
    bsps_dst_if.source             dst
);

    localparam int COL_SPAN  = 1 << COUNT_W;
    localparam int ROW_DEPTH = (MAX_ROW_BYTES < COL_SPAN) ? MAX_ROW_BYTES : COL_SPAN;
    localparam int ADDR_W    = $clog2(ROW_DEPTH);
    localparam int FRAC_MAX  = (1 << FRACTION_BITS) - 1;

    logic [FRAC_W-1:0]   frac_x_reg, frac_x_next;
    logic [FRAC_W-1:0]   frac_y_reg, frac_y_next;
    logic [CHAN_W-1:0]   chans_reg, chans_next;
    logic [WIDTH_W-1:0]  width_reg, width_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;

    logic [FRACTION_BITS-1:0] fx, fy;
    geom_t                    geom;
    item_ctrl_t               ctrl;
    logic [ADDR_W-1:0]        addr;
    byte_t                    upper_byte;
    logic                     take;
    logic                     acc;

    always_comb
    begin
        frac_x_next = frac_x_reg;
        frac_y_next = frac_y_reg;
        chans_next  = chans_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAC_X:   frac_x_next = cfg_wdata[FRAC_W-1:0];
                REG_FRAC_Y:   frac_y_next = cfg_wdata[FRAC_W-1:0];
                REG_CHANNELS: chans_next  = cfg_wdata[CHAN_W-1:0];
                REG_WIDTH:    width_next  = cfg_wdata[WIDTH_W-1:0];
                REG_HEIGHT:   height_next = cfg_wdata[HEIGHT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_x_reg <= '0;
            frac_y_reg <= '0;
            chans_reg  <= CHAN_W'(1);
            width_reg  <= WIDTH_W'(1);
            height_reg <= HEIGHT_W'(1);
        end
        else
        begin
            frac_x_reg <= frac_x_next;
            frac_y_reg <= frac_y_next;
            chans_reg  <= chans_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // fractions saturate to the largest step the weights can express
    assign fx = (32'(frac_x_reg) > FRAC_MAX) ? FRACTION_BITS'(FRAC_MAX)
                                             : FRACTION_BITS'(frac_x_reg);
    assign fy = (32'(frac_y_reg) > FRAC_MAX) ? FRACTION_BITS'(FRAC_MAX)
                                             : FRACTION_BITS'(frac_y_reg);

    assign geom.chans  = chans_reg;
    assign geom.width  = width_reg;
    assign geom.height = height_reg;

    assign acc       = src.valid && take;
    assign src.ready = take;

    bsps_addr_gen #(
        .DEPTH (ROW_DEPTH),
        .AW    (ADDR_W)
    ) u_addr_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .geom  (geom),
        .acc   (acc),
        .addr  (addr),
        .ctrl  (ctrl)
    );

    bsps_line_mem #(
        .DEPTH (ROW_DEPTH),
        .AW    (ADDR_W)
    ) u_line_mem (
        .clk   (clk),
        .en    (acc),
        .addr  (addr),
        .wdata (src.src_byte),
        .rdata (upper_byte)
    );

    bsps_interp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_interp (
        .clk        (clk),
        .rst_n      (rst_n),
        .acc        (acc),
        .ctrl       (ctrl),
        .src_byte   (src.src_byte),
        .upper_byte (upper_byte),
        .fx         (fx),
        .fy         (fy),
        .take       (take),
        .dst        (dst)
    );

endmodule
